// ===== hdl/adc_offset_calib_current_scaler_defines.svh =====
// ----------------------------------------------------------------------------
// adc_offset_calib_current_scaler_defines
// Assertion macros for the offset calibration and current scaler block.
// ----------------------------------------------------------------------------
`ifndef ADC_OFFSET_CALIB_CURRENT_SCALER_DEFINES_SVH
`define ADC_OFFSET_CALIB_CURRENT_SCALER_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every clock edge out of reset
`define ACS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("acs check failed");

// same-cycle implication
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acs implication failed");

`else

`define ACS_ASSERT(lbl, clk, rst_n, prop)
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/acs_pkg.sv =====
// ----------------------------------------------------------------------------
// acs_pkg
// Shared widths, codes and stage types of the offset calibration and
// current scaler block.
// ----------------------------------------------------------------------------
package acs_pkg;

  // adc code width and averaging length
  localparam int unsigned AdcBits  = 12;
  localparam int unsigned AvgLog2  = 10;
  localparam int unsigned RunLen   = 1 << AvgLog2;
  localparam int unsigned CntBits  = AvgLog2 + 1;
  localparam int unsigned SumBits  = AdcBits + AvgLog2;

  // gains are unsigned q4.12
  localparam int unsigned GainBits = 16;

  // result widths
  localparam int unsigned VoltBits  = AdcBits + GainBits;
  localparam int unsigned CurBits   = VoltBits + 1;
  localparam int unsigned VBits     = CurBits + 1;
  localparam int unsigned DeltaBits = VoltBits + 1;

  // stream word widths
  localparam int unsigned InFieldBits  = 3 * AdcBits;
  localparam int unsigned InDataBits   = ((InFieldBits + 7) / 8) * 8;
  localparam int unsigned OutFieldBits = 2 * CurBits + VBits + VoltBits + DeltaBits;
  localparam int unsigned OutDataBits  = ((OutFieldBits + 7) / 8) * 8;

  // configuration port
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = GainBits;
  localparam logic [GainBits-1:0] GainReset = GainBits'(4096);

  typedef enum logic [CfgIdxBits-1:0] {
    RegCurrentGain = 2'd0,
    RegCurrentSign = 2'd1,
    RegBusGain     = 2'd2
  } acs_reg_e;

  typedef enum logic {
    ModeCalib   = 1'b0,
    ModeConvert = 1'b1
  } acs_mode_e;

  typedef struct packed {
    logic [GainBits-1:0] current_gain;
    logic                current_sign;
    logic [GainBits-1:0] bus_gain;
  } acs_cfg_t;

  typedef struct packed {
    acs_mode_e          mode;
    logic [AdcBits-1:0] u_code;
    logic [AdcBits-1:0] w_code;
    logic [AdcBits-1:0] bus_code;
  } acs_item_t;

  // calibration state seen by the datapath
  typedef struct packed {
    logic [AdcBits-1:0]  u_offset;
    logic [AdcBits-1:0]  w_offset;
    logic [AdcBits-1:0]  bus_avg;
    logic [VoltBits-1:0] calib_voltage;
    logic                done_next;
    logic                done;
    logic                idle;
  } acs_cal_t;

  typedef struct packed {
    acs_mode_e                  mode;
    logic                       done;
    logic signed [CurBits-1:0]  u_prod;
    logic signed [CurBits-1:0]  w_prod;
    logic [VoltBits-1:0]        bus_prod;
  } acs_prod_t;

  typedef struct packed {
    acs_mode_e                   mode;
    logic                        done;
    logic signed [CurBits-1:0]   u;
    logic signed [VBits-1:0]     v;
    logic signed [CurBits-1:0]   w;
    logic [VoltBits-1:0]         bus;
    logic signed [DeltaBits-1:0] delta;
  } acs_res_t;

endpackage

// ===== hdl/acs_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// acs_cfg_regs
// Gain and sign registers written through the configuration channel.
// ----------------------------------------------------------------------------
module acs_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [acs_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [acs_pkg::CfgDataBits-1:0]  cfg_data_i,
  output acs_pkg::acs_cfg_t                cfg_o
);

  acs_pkg::acs_cfg_t cfg_q, cfg_d;

  // writes are always accepted, ready is tied high
  assign cfg_ready_o = 1'b1;

  // register decode, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (acs_pkg::acs_reg_e'(cfg_index_i))
        acs_pkg::RegCurrentGain: cfg_d.current_gain = cfg_data_i[acs_pkg::GainBits-1:0];
        acs_pkg::RegCurrentSign: cfg_d.current_sign = cfg_data_i[0];
        acs_pkg::RegBusGain:     cfg_d.bus_gain     = cfg_data_i[acs_pkg::GainBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.current_gain <= acs_pkg::GainReset;
      cfg_q.current_sign <= 1'b0;
      cfg_q.bus_gain     <= acs_pkg::GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/acs_calib_core.sv =====
// ----------------------------------------------------------------------------
// acs_calib_core
// Calibration run state: sample count, channel sums, offsets, calibration
// voltage, done flag; updated as each calibrate item leaves the input stage.
// ----------------------------------------------------------------------------
module acs_calib_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             move_i,
  input  acs_pkg::acs_item_t               item_i,
  input  logic [acs_pkg::VoltBits-1:0]     bus_prod_i,
  output acs_pkg::acs_cal_t                cal_o
);

  logic [acs_pkg::CntBits-1:0]  count_q, count_d;
  logic [acs_pkg::SumBits-1:0]  u_sum_q, u_sum_d;
  logic [acs_pkg::SumBits-1:0]  w_sum_q, w_sum_d;
  logic [acs_pkg::SumBits-1:0]  bus_sum_q, bus_sum_d;
  logic [acs_pkg::AdcBits-1:0]  u_off_q, u_off_d;
  logic [acs_pkg::AdcBits-1:0]  w_off_q, w_off_d;
  logic [acs_pkg::VoltBits-1:0] calib_q, calib_d;
  logic                         done_q, done_d;
  logic                         run_end;
  logic                         calib_item;

  assign run_end    = (count_q == acs_pkg::CntBits'(acs_pkg::RunLen));
  assign calib_item = (item_i.mode == acs_pkg::ModeCalib);

  // run sequencing: clear on first sample, accumulate, then close the run
  always_comb begin
    count_d   = count_q;
    u_sum_d   = u_sum_q;
    w_sum_d   = w_sum_q;
    bus_sum_d = bus_sum_q;
    u_off_d   = u_off_q;
    w_off_d   = w_off_q;
    calib_d   = calib_q;
    done_d    = done_q;
    if (move_i && calib_item) begin
      if (run_end) begin
        u_off_d = u_sum_q[acs_pkg::AvgLog2 +: acs_pkg::AdcBits];
        w_off_d = w_sum_q[acs_pkg::AvgLog2 +: acs_pkg::AdcBits];
        calib_d = bus_prod_i;
        count_d = '0;
        done_d  = 1'b1;
      end else if (count_q == '0) begin
        u_sum_d   = acs_pkg::SumBits'(item_i.u_code);
        w_sum_d   = acs_pkg::SumBits'(item_i.w_code);
        bus_sum_d = acs_pkg::SumBits'(item_i.bus_code);
        count_d   = count_q + acs_pkg::CntBits'(1);
        done_d    = 1'b0;
      end else begin
        u_sum_d   = u_sum_q + acs_pkg::SumBits'(item_i.u_code);
        w_sum_d   = w_sum_q + acs_pkg::SumBits'(item_i.w_code);
        bus_sum_d = bus_sum_q + acs_pkg::SumBits'(item_i.bus_code);
        count_d   = count_q + acs_pkg::CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      u_sum_q   <= '0;
      w_sum_q   <= '0;
      bus_sum_q <= '0;
      u_off_q   <= '0;
      w_off_q   <= '0;
      calib_q   <= '0;
      done_q    <= 1'b0;
    end else begin
      count_q   <= count_d;
      u_sum_q   <= u_sum_d;
      w_sum_q   <= w_sum_d;
      bus_sum_q <= bus_sum_d;
      u_off_q   <= u_off_d;
      w_off_q   <= w_off_d;
      calib_q   <= calib_d;
      done_q    <= done_d;
    end
  end

  // done as seen after the item now in the input stage
  assign cal_o.u_offset      = u_off_q;
  assign cal_o.w_offset      = w_off_q;
  assign cal_o.bus_avg       = bus_sum_q[acs_pkg::AvgLog2 +: acs_pkg::AdcBits];
  assign cal_o.calib_voltage = calib_q;
  assign cal_o.done_next     = calib_item ? run_end : done_q;
  assign cal_o.done          = done_q;
  assign cal_o.idle          = (count_q == '0);

endmodule

// ===== hdl/acs_mul_stage.sv =====
// ----------------------------------------------------------------------------
// acs_mul_stage
// Input register, offset subtraction and gain multipliers, product register.
// The bus multiplier also forms the calibration voltage when a run closes.
// ----------------------------------------------------------------------------
module acs_mul_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  acs_pkg::acs_item_t            item_i,
  input  acs_pkg::acs_cfg_t             cfg_i,
  input  acs_pkg::acs_cal_t             cal_i,
  output logic                          move_o,
  output acs_pkg::acs_item_t            item_o,
  output logic [acs_pkg::VoltBits-1:0]  bus_prod_o,
  output logic                          prod_valid_o,
  input  logic                          prod_ready_i,
  output acs_pkg::acs_prod_t            prod_o
);

  acs_pkg::acs_item_t a_q;
  logic               a_valid_q, a_valid_d;
  acs_pkg::acs_prod_t b_q, b_d;
  logic               b_valid_q, b_valid_d;
  logic               b_free;

  logic signed [acs_pkg::AdcBits:0]  u_diff, w_diff;
  logic signed [acs_pkg::GainBits:0] gain_s;
  logic signed [acs_pkg::CurBits:0]  u_full, w_full;
  logic [acs_pkg::AdcBits-1:0]       bus_op;

  // stage handshake
  assign b_free    = !b_valid_q || prod_ready_i;
  assign move_o    = a_valid_q && b_free;
  assign s_ready_o = !a_valid_q || b_free;

  assign a_valid_d = s_ready_o ? s_valid_i : a_valid_q;
  assign b_valid_d = b_free ? a_valid_q : b_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      b_valid_q <= b_valid_d;
    end
  end

  // offset correction and current products
  assign u_diff = $signed({1'b0, a_q.u_code}) - $signed({1'b0, cal_i.u_offset});
  assign w_diff = $signed({1'b0, a_q.w_code}) - $signed({1'b0, cal_i.w_offset});
  assign gain_s = $signed({1'b0, cfg_i.current_gain});
  assign u_full = (acs_pkg::CurBits+1)'(u_diff) * (acs_pkg::CurBits+1)'(gain_s);
  assign w_full = (acs_pkg::CurBits+1)'(w_diff) * (acs_pkg::CurBits+1)'(gain_s);

  // bus code in convert mode, averaged bus sum in calibrate mode (used when a run closes)
  assign bus_op     = (a_q.mode == acs_pkg::ModeConvert) ? a_q.bus_code : cal_i.bus_avg;
  assign bus_prod_o = acs_pkg::VoltBits'(bus_op) * acs_pkg::VoltBits'(cfg_i.bus_gain);

  always_comb begin
    b_d.mode     = a_q.mode;
    b_d.done     = cal_i.done_next;
    b_d.u_prod   = u_full[acs_pkg::CurBits-1:0];
    b_d.w_prod   = w_full[acs_pkg::CurBits-1:0];
    b_d.bus_prod = bus_prod_o;
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      a_q <= item_i;
    end
    if (move_o) begin
      b_q <= b_d;
    end
  end

  assign item_o       = a_q;
  assign prod_valid_o = b_valid_q;
  assign prod_o       = b_q;

endmodule

// ===== hdl/acs_out_stage.sv =====
// ----------------------------------------------------------------------------
// acs_out_stage
// Sign, third phase, bus delta and calibrate-mode zeroing into the result
// register.
// ----------------------------------------------------------------------------
module acs_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          prod_valid_i,
  output logic                          prod_ready_o,
  input  acs_pkg::acs_prod_t            prod_i,
  input  logic                          sign_i,
  input  logic [acs_pkg::VoltBits-1:0]  calib_voltage_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output acs_pkg::acs_res_t             res_o
);

  acs_pkg::acs_res_t res_q, res_d;
  logic              res_valid_q, res_valid_d;
  logic              r_free;

  logic signed [acs_pkg::VBits-1:0]     uw_sum;
  logic signed [acs_pkg::DeltaBits-1:0] delta;

  // result register handshake
  assign r_free       = !res_valid_q || res_ready_i;
  assign prod_ready_o = r_free;
  assign res_valid_d  = r_free ? prod_valid_i : res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  // v is the negated sum of the signed u and w currents
  assign uw_sum = acs_pkg::VBits'(prod_i.u_prod) + acs_pkg::VBits'(prod_i.w_prod);
  assign delta  = $signed(acs_pkg::DeltaBits'(prod_i.bus_prod))
                - $signed(acs_pkg::DeltaBits'(calib_voltage_i));

  always_comb begin
    res_d.mode  = prod_i.mode;
    res_d.done  = prod_i.done;
    res_d.u     = '0;
    res_d.v     = '0;
    res_d.w     = '0;
    res_d.bus   = '0;
    res_d.delta = '0;
    if (prod_i.mode == acs_pkg::ModeConvert) begin
      res_d.u     = sign_i ? -prod_i.u_prod : prod_i.u_prod;
      res_d.w     = sign_i ? -prod_i.w_prod : prod_i.w_prod;
      res_d.v     = sign_i ? uw_sum : -uw_sum;
      res_d.bus   = prod_i.bus_prod;
      res_d.delta = delta;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_free && prod_valid_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== hdl/adc_offset_calib_current_scaler.sv =====
// ----------------------------------------------------------------------------
// adc_offset_calib_current_scaler
// ADC zero-offset calibration and phase current / bus voltage scaling.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                       payload
//  s_axis    in    s_axis_tvalid / s_axis_tready   tdata codes, tuser mode
//  m_axis    out   m_axis_tvalid / m_axis_tready   tdata results, tuser done
//  cfg       in    cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// One word in and one word out per cycle while m_axis_tready is high; an
// accepted word passes the product register, then the result register.
// The gain multipliers sit between the input and product registers.
// Reset loads the gains to 1.0, the sign to plus, and zeroes the offsets,
// calibration voltage, run count and done flag.
// With m_axis_tready low the three stages fill up; s_axis_tready drops only
// when all of them hold a word. Configuration writes are always accepted.
//
`include "adc_offset_calib_current_scaler_defines.svh"

module adc_offset_calib_current_scaler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // fields from bit 0: u_code, w_code, bus_code, zero pad
  input  logic [acs_pkg::InDataBits-1:0]    s_axis_tdata,
  // fields from bit 0: mode
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // fields from bit 0: u_current, v_current, w_current, bus_volts, bus_delta,
  // zero pad
  output logic [acs_pkg::OutDataBits-1:0]   m_axis_tdata,
  // fields from bit 0: calib_done
  output logic                              m_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [acs_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [acs_pkg::CfgDataBits-1:0]   cfg_data_i
);

  acs_pkg::acs_cfg_t  cfg;
  acs_pkg::acs_item_t in_item;
  acs_pkg::acs_item_t a_item;
  acs_pkg::acs_cal_t  cal;
  acs_pkg::acs_prod_t prod;
  acs_pkg::acs_res_t  res;
  logic                         a_move;
  logic [acs_pkg::VoltBits-1:0] bus_prod;
  logic                         prod_valid;
  logic                         prod_ready;
  logic signed [acs_pkg::VBits-1:0] v_chk;
  logic                         calib_res;

  // unpack the input word
  assign in_item.mode     = acs_pkg::acs_mode_e'(s_axis_tuser);
  assign in_item.u_code   = s_axis_tdata[0 +: acs_pkg::AdcBits];
  assign in_item.w_code   = s_axis_tdata[acs_pkg::AdcBits +: acs_pkg::AdcBits];
  assign in_item.bus_code = s_axis_tdata[2*acs_pkg::AdcBits +: acs_pkg::AdcBits];

  acs_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  acs_calib_core u_calib_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .move_i     (a_move),
    .item_i     (a_item),
    .bus_prod_i (bus_prod),
    .cal_o      (cal)
  );

  acs_mul_stage u_mul_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .item_i       (in_item),
    .cfg_i        (cfg),
    .cal_i        (cal),
    .move_o       (a_move),
    .item_o       (a_item),
    .bus_prod_o   (bus_prod),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  acs_out_stage u_out_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .prod_valid_i    (prod_valid),
    .prod_ready_o    (prod_ready),
    .prod_i          (prod),
    .sign_i          (cfg.current_sign),
    .calib_voltage_i (cal.calib_voltage),
    .res_valid_o     (m_axis_tvalid),
    .res_ready_i     (m_axis_tready),
    .res_o           (res)
  );

  // pack the result word
  assign m_axis_tdata = acs_pkg::OutDataBits'({res.delta, res.bus, res.w, res.v, res.u});
  assign m_axis_tuser = res.done;

  // third phase recomputed from the delivered u and w
  assign v_chk = -(acs_pkg::VBits'(res.u) + acs_pkg::VBits'(res.w));

  assign calib_res = (res.mode == acs_pkg::ModeCalib);

  // calibrate-mode results carry no measurement
  `ACS_ASSERT_IMP(a_calib_zero, clk_i, rst_ni, m_axis_tvalid && calib_res, m_axis_tdata == '0)
  // phase currents always sum to zero
  `ACS_ASSERT_IMP(a_phase_sum, clk_i, rst_ni, m_axis_tvalid, res.v == v_chk)
  // done is set only by the item that closes a run
  `ACS_ASSERT_IMP(a_done_run_end, clk_i, rst_ni, $rose(cal.done), cal.idle)
  // input back-pressure only with a full pipe and a waiting result
  `ACS_ASSERT_IMP(a_stall_full, clk_i, rst_ni, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule
